// ===== rtl/core/psgrf_pkg.sv =====
`default_nettype none

package psgrf_pkg;

  // dividend range reaches 24 bits
  localparam int DIV_W = 24;
  localparam int PITCH_W = 17;
  localparam logic [DIV_W-1:0] FREQ_DIVIDEND_DEF = 24'd111861;

  localparam int QDEPTH = 4;

  // bus ports
  localparam logic [7:0] PORT_SEL = 8'ha0;
  localparam logic [7:0] PORT_WR = 8'ha1;
  localparam logic [7:0] PORT_RD = 8'ha2;

  localparam logic [7:0] GPIO_IN_BYTE = 8'h3f;

  // register map
  localparam logic [7:0] REG_TONE_A_FINE = 8'd0;
  localparam logic [7:0] REG_TONE_A_COARSE = 8'd1;
  localparam logic [7:0] REG_TONE_B_FINE = 8'd2;
  localparam logic [7:0] REG_TONE_B_COARSE = 8'd3;
  localparam logic [7:0] REG_TONE_C_FINE = 8'd4;
  localparam logic [7:0] REG_TONE_C_COARSE = 8'd5;
  localparam logic [7:0] REG_NOISE = 8'd6;
  localparam logic [7:0] REG_MIXER = 8'd7;
  localparam logic [7:0] REG_AMP_A = 8'd8;
  localparam logic [7:0] REG_AMP_B = 8'd9;
  localparam logic [7:0] REG_AMP_C = 8'd10;
  localparam logic [7:0] REG_ENV_FINE = 8'd11;
  localparam logic [7:0] REG_ENV_COARSE = 8'd12;
  localparam logic [7:0] REG_ENV_SHAPE = 8'd13;
  localparam logic [7:0] REG_GPIO_DATA = 8'd14;
  localparam logic [7:0] REG_GPIO_DIR = 8'd15;

  // mixer bits belonging to each voice (tone and noise disable)
  localparam logic [7:0] MIX_VOICE_A = 8'b0000_1001;
  localparam logic [7:0] MIX_VOICE_B = 8'b0001_0010;
  localparam logic [7:0] MIX_VOICE_C = 8'b0010_0100;

  localparam logic [2:0] NOISE_CHAN_BASE = 3'd3;
  localparam logic [3:0] LEVEL_ENV = 4'hf;

  typedef struct packed {
    logic        is_command;
    logic [7:0]  read_data;
    logic [2:0]  chan;
    logic        enabled;
    logic [11:0] period;
    logic [4:0]  amp;
    logic [3:0]  shape;
    logic [15:0] eg_period;
    logic        last;
  } entry_t;

  typedef struct packed {
    logic [7:0]         read_data;
    logic               is_command;
    logic [2:0]         channel_index;
    logic               sound_on;
    logic [PITCH_W-1:0] pitch_frequency;
    logic               volume_valid;
    logic [3:0]         volume_level;
    logic               envelope_enable;
    logic [3:0]         envelope_shape;
    logic [15:0]        envelope_period;
    logic               last;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/psg_register_command_front.sv =====
`default_nettype none

// Register front of a three-voice sound generator. An access (op, port, value) is taken
// when start is high and busy is low. A select write (port a0) or a data write that
// touches no voice finishes at once and busy stays low. A read gives one result; a data
// write that touches voices gives two commands per voice, tone then noise, voices A to
// C, last set on the final one. Each command whose generator is on runs a radix-2
// divider of one quotient bit per cycle; off commands and reads skip the divider. The back
// end takes the next queue entry only when it has finished the previous one.
// The classifier keeps busy high while it fills a four-entry queue to the divider. Each
// result stands on the outputs for one cycle with strobe high; the receiver cannot stall.
module psg_register_command_front #(
  parameter logic [psgrf_pkg::DIV_W-1:0] FREQ_DIVIDEND = psgrf_pkg::FREQ_DIVIDEND_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        op,
  input  logic [7:0]  port,
  input  logic [7:0]  value,
  output logic        strobe,
  output logic [7:0]  read_data,
  output logic        is_command,
  output logic [2:0]  channel_index,
  output logic        sound_on,
  output logic [16:0] pitch_frequency,
  output logic        volume_valid,
  output logic [3:0]  volume_level,
  output logic        envelope_enable,
  output logic [3:0]  envelope_shape,
  output logic [15:0] envelope_period,
  output logic        last
);

  logic               q_push;
  logic               q_pop;
  logic               q_full;
  logic               q_empty;
  psgrf_pkg::entry_t  q_wdata;
  psgrf_pkg::entry_t  q_rdata;
  psgrf_pkg::result_t res;

  psgrf_front u_front (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .op     (op),
    .port   (port),
    .value  (value),
    .busy   (busy),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_wdata)
  );

  psgrf_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  psgrf_back #(
    .FREQ_DIVIDEND (FREQ_DIVIDEND)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .q_rdata (q_rdata),
    .strobe  (strobe),
    .res     (res)
  );

  assign read_data = res.read_data;
  assign is_command = res.is_command;
  assign channel_index = res.channel_index;
  assign sound_on = res.sound_on;
  assign pitch_frequency = res.pitch_frequency;
  assign volume_valid = res.volume_valid;
  assign volume_level = res.volume_level;
  assign envelope_enable = res.envelope_enable;
  assign envelope_shape = res.envelope_shape;
  assign envelope_period = res.envelope_period;
  assign last = res.last;

endmodule

`default_nettype wire

// ===== rtl/core/psgrf_queue.sv =====
`default_nettype none

module psgrf_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  psgrf_pkg::entry_t    wdata,
  input  logic                 pop,
  output psgrf_pkg::entry_t    rdata,
  output logic                 full,
  output logic                 empty
);

  localparam int AW = $clog2(psgrf_pkg::QDEPTH);
  localparam int CW = $clog2(psgrf_pkg::QDEPTH + 1);

  psgrf_pkg::entry_t mem [psgrf_pkg::QDEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full = (count == CW'(psgrf_pkg::QDEPTH));
  assign empty = (count == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
    if (do_pop) begin
      rdata <= mem[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= AW'(wr_ptr + 1'b1);
      end
      if (do_pop) begin
        rd_ptr <= AW'(rd_ptr + 1'b1);
      end
      if (do_push && !do_pop) begin
        count <= CW'(count + 1'b1);
      end else if (do_pop && !do_push) begin
        count <= CW'(count - 1'b1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/psgrf_front.sv =====
`default_nettype none

module psgrf_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              op,
  input  logic [7:0]        port,
  input  logic [7:0]        value,
  output logic              busy,
  input  logic              q_full,
  output logic              q_push,
  output psgrf_pkg::entry_t q_data
);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_READ = 3'b010,
    F_SEQ  = 3'b100
  } fstate_t;

  fstate_t     state;
  logic [7:0]  sel;
  logic [11:0] tone_period [3];
  logic [4:0]  noise_period;
  logic [7:0]  mixer_bits;
  logic [4:0]  amplitude [3];
  logic [15:0] eg_period_reg;
  logic [3:0]  eg_shape_reg;
  logic [7:0]  gpio_direction;

  logic [7:0]  rd_byte;
  logic [7:0]  rd_byte_next;
  logic [2:0]  mask;
  logic [2:0]  mask_rest;
  logic [2:0]  upd;
  logic [7:0]  diff;
  logic        sub;
  logic [1:0]  v_cur;
  logic        accept;

  assign busy = (state != F_IDLE);
  assign accept = start && !busy;

  always_comb begin
    if (mask[0]) begin
      v_cur = 2'd0;
    end else if (mask[1]) begin
      v_cur = 2'd1;
    end else begin
      v_cur = 2'd2;
    end
  end

  assign mask_rest = mask & ~(3'b001 << v_cur);

  always_comb begin
    rd_byte_next = 8'h00;
    if (port == psgrf_pkg::PORT_RD) begin
      if (sel == psgrf_pkg::REG_GPIO_DATA) begin
        rd_byte_next = psgrf_pkg::GPIO_IN_BYTE;
      end else if (sel == psgrf_pkg::REG_GPIO_DIR) begin
        rd_byte_next = gpio_direction;
      end
    end
  end

  // voices touched by a data write to the selected register
  always_comb begin
    diff = mixer_bits ^ value;
    case (sel)
      psgrf_pkg::REG_TONE_A_FINE, psgrf_pkg::REG_TONE_A_COARSE,
      psgrf_pkg::REG_TONE_B_FINE, psgrf_pkg::REG_TONE_B_COARSE,
      psgrf_pkg::REG_TONE_C_FINE, psgrf_pkg::REG_TONE_C_COARSE: begin
        upd = 3'b001 << sel[2:1];
      end
      psgrf_pkg::REG_NOISE: begin
        upd = 3'b111;
      end
      psgrf_pkg::REG_MIXER: begin
        upd = {|(diff & psgrf_pkg::MIX_VOICE_C), |(diff & psgrf_pkg::MIX_VOICE_B),
               |(diff & psgrf_pkg::MIX_VOICE_A)};
      end
      psgrf_pkg::REG_AMP_A, psgrf_pkg::REG_AMP_B, psgrf_pkg::REG_AMP_C: begin
        upd = 3'b001 << sel[1:0];
      end
      psgrf_pkg::REG_ENV_SHAPE: begin
        upd = {amplitude[2][4], amplitude[1][4], amplitude[0][4]};
      end
      default: begin
        upd = 3'b000;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      sel <= '0;
      tone_period[0] <= '0;
      tone_period[1] <= '0;
      tone_period[2] <= '0;
      noise_period <= '0;
      mixer_bits <= '0;
      amplitude[0] <= '0;
      amplitude[1] <= '0;
      amplitude[2] <= '0;
      eg_period_reg <= '0;
      eg_shape_reg <= '0;
      gpio_direction <= '0;
      mask <= '0;
      sub <= 1'b0;
      rd_byte <= '0;
    end else begin
      case (state)
        F_IDLE: begin
          if (accept) begin
            if (!op) begin
              rd_byte <= rd_byte_next;
              state <= F_READ;
            end else if (port == psgrf_pkg::PORT_SEL) begin
              sel <= value;
            end else if (port == psgrf_pkg::PORT_WR) begin
              case (sel)
                psgrf_pkg::REG_TONE_A_FINE, psgrf_pkg::REG_TONE_B_FINE,
                psgrf_pkg::REG_TONE_C_FINE: begin
                  tone_period[sel[2:1]][7:0] <= value;
                end
                psgrf_pkg::REG_TONE_A_COARSE, psgrf_pkg::REG_TONE_B_COARSE,
                psgrf_pkg::REG_TONE_C_COARSE: begin
                  tone_period[sel[2:1]][11:8] <= value[3:0];
                end
                psgrf_pkg::REG_NOISE: begin
                  noise_period <= value[4:0];
                end
                psgrf_pkg::REG_MIXER: begin
                  mixer_bits <= value;
                end
                psgrf_pkg::REG_AMP_A, psgrf_pkg::REG_AMP_B, psgrf_pkg::REG_AMP_C: begin
                  amplitude[sel[1:0]] <= value[4:0];
                end
                psgrf_pkg::REG_ENV_FINE: begin
                  eg_period_reg[7:0] <= value;
                end
                psgrf_pkg::REG_ENV_COARSE: begin
                  eg_period_reg[15:8] <= value;
                end
                psgrf_pkg::REG_ENV_SHAPE: begin
                  eg_shape_reg <= value[3:0];
                end
                psgrf_pkg::REG_GPIO_DIR: begin
                  gpio_direction <= value;
                end
                default: begin
                end
              endcase
              if (upd != 3'b000) begin
                mask <= upd;
                sub <= 1'b0;
                state <= F_SEQ;
              end
            end
          end
        end
        F_READ: begin
          if (!q_full) begin
            state <= F_IDLE;
          end
        end
        F_SEQ: begin
          // tone command first, then noise command of the same voice
          if (!q_full) begin
            if (!sub) begin
              sub <= 1'b1;
            end else begin
              sub <= 1'b0;
              mask <= mask_rest;
              if (mask_rest == 3'b000) begin
                state <= F_IDLE;
              end
            end
          end
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    q_data = '0;
    q_push = 1'b0;
    case (state)
      F_READ: begin
        q_push = !q_full;
        q_data.read_data = rd_byte;
        q_data.last = 1'b1;
      end
      F_SEQ: begin
        q_push = !q_full;
        q_data.is_command = 1'b1;
        q_data.amp = amplitude[v_cur];
        q_data.shape = eg_shape_reg;
        q_data.eg_period = eg_period_reg;
        if (sub) begin
          q_data.chan = {1'b0, v_cur} + psgrf_pkg::NOISE_CHAN_BASE;
          q_data.enabled = !mixer_bits[{1'b0, v_cur} + psgrf_pkg::NOISE_CHAN_BASE];
          q_data.period = {7'b0, noise_period};
          q_data.last = (mask_rest == 3'b000);
        end else begin
          q_data.chan = {1'b0, v_cur};
          q_data.enabled = !mixer_bits[{1'b0, v_cur}];
          q_data.period = tone_period[v_cur];
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/psgrf_back.sv =====
`default_nettype none

module psgrf_back #(
  parameter logic [psgrf_pkg::DIV_W-1:0] FREQ_DIVIDEND = psgrf_pkg::FREQ_DIVIDEND_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  output logic               q_pop,
  input  psgrf_pkg::entry_t  q_rdata,
  output logic               strobe,
  output psgrf_pkg::result_t res
);

  localparam int DW = psgrf_pkg::DIV_W;
  localparam int PW = psgrf_pkg::PITCH_W;
  localparam int CW = $clog2(DW);

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_LOAD = 3'b010,
    B_DIV  = 3'b100
  } bstate_t;

  bstate_t           state;
  psgrf_pkg::entry_t ent;
  logic [11:0]       rem;
  logic [12:0]       rem_shift;
  logic              q_bit;
  logic [DW-1:0]     dvd;
  logic [DW-1:0]     quo;
  logic [DW-1:0]     quo_next;
  logic [PW-1:0]     pitch_sat;
  logic [CW-1:0]     cnt;
  logic              load_on;

  function automatic psgrf_pkg::result_t make_result(psgrf_pkg::entry_t e, logic on,
                                                     logic [PW-1:0] pitch);
    psgrf_pkg::result_t r;
    r = '0;
    r.read_data = e.read_data;
    r.last = e.last;
    if (e.is_command) begin
      r.read_data = '0;
      r.is_command = 1'b1;
      r.channel_index = e.chan;
      r.sound_on = on;
      r.envelope_shape = e.shape;
      r.envelope_period = e.eg_period;
      if (on) begin
        r.pitch_frequency = pitch;
        r.volume_valid = 1'b1;
        r.volume_level = e.amp[4] ? psgrf_pkg::LEVEL_ENV : e.amp[3:0];
        r.envelope_enable = e.amp[4];
      end else begin
        // in envelope mode an idle generator keeps its previous volume
        r.volume_valid = !e.amp[4];
      end
    end
    return r;
  endfunction

  assign q_pop = (state == B_IDLE) && !q_empty;
  assign load_on = q_rdata.is_command && q_rdata.enabled && (q_rdata.period != '0);

  // restoring divider, one quotient bit a cycle
  assign rem_shift = {rem, dvd[DW-1]};
  assign q_bit = (rem_shift >= {1'b0, ent.period});
  assign quo_next = {quo[DW-2:0], q_bit};
  assign pitch_sat = (|quo_next[DW-1:PW]) ? '1 : quo_next[PW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (state)
        B_IDLE: begin
          if (!q_empty) begin
            state <= B_LOAD;
          end
        end
        B_LOAD: begin
          if (load_on) begin
            state <= B_DIV;
          end else begin
            strobe <= 1'b1;
            state <= B_IDLE;
          end
        end
        B_DIV: begin
          if (cnt == '0) begin
            strobe <= 1'b1;
            state <= B_IDLE;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_LOAD: begin
        ent <= q_rdata;
        rem <= '0;
        dvd <= FREQ_DIVIDEND;
        quo <= '0;
        cnt <= CW'(DW - 1);
        if (!load_on) begin
          res <= make_result(q_rdata, 1'b0, '0);
        end
      end
      B_DIV: begin
        rem <= q_bit ? 12'(rem_shift - {1'b0, ent.period}) : rem_shift[11:0];
        dvd <= {dvd[DW-2:0], 1'b0};
        quo <= quo_next;
        cnt <= CW'(cnt - 1'b1);
        if (cnt == '0) begin
          res <= make_result(ent, 1'b1, pitch_sat);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/psgrf_checker.sv =====
`default_nettype none

module psgrf_checker (
  input logic        clk,
  input logic        rst,
  input logic        strobe,
  input logic [7:0]  read_data,
  input logic        is_command,
  input logic [2:0]  channel_index,
  input logic        sound_on,
  input logic [16:0] pitch_frequency,
  input logic        volume_valid,
  input logic        envelope_enable,
  input logic        last
);

  // a read result is a single, bare transfer
  a_read_shape: assert property (@(posedge clk) disable iff (rst)
    strobe && !is_command |-> last && (channel_index == 3'd0) && !sound_on)
    else $error("read result carries command fields");

  a_chan_range: assert property (@(posedge clk) disable iff (rst)
    strobe && is_command |-> (channel_index <= 3'd5) && (read_data == 8'h00))
    else $error("command with bad channel or read byte");

  a_off_quiet: assert property (@(posedge clk) disable iff (rst)
    strobe && is_command && !sound_on |-> (pitch_frequency == 17'd0) && !envelope_enable)
    else $error("silent generator with pitch or envelope");

  a_on_volume: assert property (@(posedge clk) disable iff (rst)
    strobe && is_command && sound_on |-> volume_valid)
    else $error("active generator without volume");

  // the divider back end never delivers in two adjacent cycles
  a_strobe_gap: assert property (@(posedge clk) disable iff (rst)
    strobe |=> !strobe)
    else $error("back-to-back result strobes");

endmodule

bind psg_register_command_front psgrf_checker u_checker (
  .clk             (clk),
  .rst             (rst),
  .strobe          (strobe),
  .read_data       (read_data),
  .is_command      (is_command),
  .channel_index   (channel_index),
  .sound_on        (sound_on),
  .pitch_frequency (pitch_frequency),
  .volume_valid    (volume_valid),
  .envelope_enable (envelope_enable),
  .last            (last)
);

`default_nettype wire
